// File: rtl/pdsps_pkg.sv
// ----------------------------------------------------------------------------
// PD servo stepper package
// Word types, command and status codes, register indexes and sizing constants
// that are shared by the stepper RTL.
// ----------------------------------------------------------------------------
package pdsps_pkg;

  localparam int CHANNELS = 5;

  // Radix-4 long division of a 56-bit dividend: two quotient bits a cycle.
  localparam int DIV_NUM_W = 56;
  localparam int DIV_STEPS = DIV_NUM_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [31:0] MIN_DT_US    = 32'd1000;
  localparam logic [31:0] US_PER_SEC   = 32'd1000000;

  // ceil(2^45 / 15625): with a prior shift by 6 this divides a 37-bit value
  // by one million exactly.
  localparam logic [31:0] LIM_RECIP    = 32'd2251799814;
  // Any speed limit at or above this value cannot change the clamped angle.
  localparam logic [17:0] LIM_SAT      = 18'd131072;

  typedef enum logic [1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_STEP       = 2'd1,
    CMD_HOME       = 2'd2,
    CMD_UNUSED     = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    STAT_MOVED    = 3'd0,
    STAT_DEADZONE = 3'd1,
    STAT_DT_SMALL = 3'd2,
    STAT_TARGET   = 3'd3,
    STAT_HOMED    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_P_GAIN       = 3'd0,
    REG_D_GAIN       = 3'd1,
    REG_MAX_VELOCITY = 3'd2,
    REG_MIN_ANGLE    = 3'd3,
    REG_MAX_ANGLE    = 3'd4,
    REG_DEAD_ZONE    = 3'd5,
    REG_HOME_ANGLE   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  channel;
    logic [15:0] angle;
    logic [31:0] time_now;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_channel;
    logic [15:0] virtual_angle;
    logic [15:0] target_angle;
    logic [2:0]  status;
  } out_word_t;

endpackage

// File: rtl/pd_servo_position_stepper_unit.sv
// ----------------------------------------------------------------------------
// PD servo position stepper
// Multi-channel PD position stepper with rate limit, dead zone and clamping.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on the input channel (in_valid, in_stall, in_word) and results
// leave on the output channel (out_valid, out_stall, out_word), one result
// per home command and per set-target or step command on a valid channel.
// An unused command code, or a set-target or step with a channel number
// beyond the last channel, is taken and dropped without a result.
// Set-target and home complete in the cycle they are taken; the result is
// valid on the next cycle. A step that ends in the dead zone or with too short
// a time step goes from evaluation straight to finish; a step that moves
// runs the shared radix-4 divider for the derivative quotient, takes the speed
// limit from a reciprocal product, and uses the shared multiplier five times.
// The block takes one word at a time; in_stall is high while a step is in
// progress and while a finished result is held by out_stall.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken every cycle.
// Reset (rst, synchronous) restores the default registers and puts every
// channel at the default home angle with zero error and zero time.
// ----------------------------------------------------------------------------
module pd_servo_position_stepper_unit
  import pdsps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_EVAL  = 11'b000_0000_0010,
    ST_MUL_D = 11'b000_0000_0100,
    ST_MUL_S = 11'b000_0000_1000,
    ST_DIV_D = 11'b000_0001_0000,
    ST_MUL_V = 11'b000_0010_0000,
    ST_MUL_R = 11'b000_0100_0000,
    ST_MUL_P = 11'b000_1000_0000,
    ST_SUM   = 11'b001_0000_0000,
    ST_APPLY = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic [15:0] p_gain, d_gain, lower_angle, upper_angle, dead_zone, home_angle;
  logic [23:0] max_velocity;

  logic [15:0]        current_angle  [CHANNELS];
  logic [15:0]        goal_angle     [CHANNELS];
  logic signed [16:0] previous_error [CHANNELS];
  logic [31:0]        previous_time  [CHANNELS];

  logic [2:0]         ch;
  logic [31:0]        now;
  logic [2:0]         stat;
  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic [31:0]        dus;
  logic               dsign;
  logic [45:0]        dquo;
  logic signed [68:0] prod;
  logic signed [40:0] outv;
  logic [17:0]        vlim;

  // Shared divider.
  logic [31:0]          rem;
  logic [31:0]          den;
  logic [DIV_NUM_W-1:0] numq;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic in_accept, in_range, out_load;
  logic signed [16:0] eval_err, eval_mag;
  logic signed [17:0] eval_diff;
  logic [31:0]        eval_dus;

  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] product;
  logic signed [35:0] dprod;
  logic [35:0]        dmag;

  logic [31:0] rem_a, rem_b;
  logic        q_a, q_b;

  logic signed [47:0] sum, dterm;
  logic [47:0]        sum_mag;
  logic signed [40:0] lim_s, cl, nv;
  logic [15:0]        nv_clamped;
  logic [15:0]        set_clamped;

  function automatic logic [15:0] clamp_angle(input logic signed [40:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
    logic signed [40:0] los, his;
    los = $signed({25'd0, lo});
    his = $signed({25'd0, hi});
    if (v < los) begin
      return lo;
    end else if (v > his) begin
      return hi;
    end
    return v[15:0];
  endfunction

  // One restoring step: shift in a dividend bit and subtract if it fits.
  function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                           input logic [31:0] d);
    logic [32:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      return {1'b1, 32'(t - {1'b0, d})};
    end
    return {1'b0, t[31:0]};
  endfunction

  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_word.channel} < 4'(CHANNELS));

  // A new result word is loaded by an immediate command or by a finished step.
  assign out_load = (state == ST_FIN && (!out_valid || !out_stall)) ||
                    (in_accept && (in_word.command == CMD_HOME ||
                                   (in_word.command == CMD_SET_TARGET && in_range)));

  assign eval_err  = $signed({1'b0, goal_angle[ch]}) - $signed({1'b0, current_angle[ch]});
  assign eval_mag  = eval_err[16] ? -eval_err : eval_err;
  assign eval_diff = 18'(eval_err) - 18'(previous_error[ch]);
  assign eval_dus  = now - previous_time[ch];

  assign dprod = prod[35:0];
  assign dmag  = dprod[35] ? 36'(-dprod) : 36'(dprod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_D: begin
        mul_a = 36'(diff);
        mul_b = $signed({17'd0, d_gain});
      end
      ST_MUL_S: begin
        mul_a = $signed(dmag);
        mul_b = $signed({1'b0, US_PER_SEC});
      end
      ST_MUL_V: begin
        mul_a = $signed({12'd0, max_velocity});
        mul_b = $signed({1'b0, dus});
      end
      ST_MUL_R: begin
        mul_a = $signed({5'd0, prod[36:6]});
        mul_b = $signed({1'b0, LIM_RECIP});
      end
      ST_MUL_P: begin
        mul_a = 36'(err);
        mul_b = $signed({17'd0, p_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  assign {q_a, rem_a} = div_step(rem, numq[DIV_NUM_W-1], den);
  assign {q_b, rem_b} = div_step(rem_a, numq[DIV_NUM_W-2], den);

  // Sum of both terms, then truncation toward zero of the Q8.8 product.
  assign dterm   = dsign ? -$signed({2'b0, dquo}) : $signed({2'b0, dquo});
  assign sum     = prod[47:0] + dterm;
  assign sum_mag = sum[47] ? 48'(-sum) : 48'(sum);

  assign lim_s = $signed({23'd0, vlim});
  always_comb begin
    if (outv > lim_s) begin
      cl = lim_s;
    end else if (outv < -lim_s) begin
      cl = -lim_s;
    end else begin
      cl = outv;
    end
  end
  assign nv          = $signed({25'd0, current_angle[ch]}) + cl;
  assign nv_clamped  = clamp_angle(nv, lower_angle, upper_angle);
  assign set_clamped = clamp_angle($signed({25'd0, in_word.angle}), lower_angle, upper_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain       <= 16'd256;
      d_gain       <= 16'd0;
      max_velocity <= 24'd23040;
      lower_angle  <= 16'd0;
      upper_angle  <= 16'd46080;
      dead_zone    <= 16'd128;
      home_angle   <= 16'd23040;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_GAIN:       p_gain       <= cfg_data[15:0];
        REG_D_GAIN:       d_gain       <= cfg_data[15:0];
        REG_MAX_VELOCITY: max_velocity <= cfg_data;
        REG_MIN_ANGLE:    lower_angle  <= cfg_data[15:0];
        REG_MAX_ANGLE:    upper_angle  <= cfg_data[15:0];
        REG_DEAD_ZONE:    dead_zone    <= cfg_data[15:0];
        REG_HOME_ANGLE:   home_angle   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        current_angle[i]  <= 16'd23040;
        goal_angle[i]     <= 16'd23040;
        previous_error[i] <= '0;
        previous_time[i]  <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            ch  <= in_word.channel;
            now <= in_word.time_now;
            if (in_word.command == CMD_HOME) begin
              for (int i = 0; i < CHANNELS; i++) begin
                current_angle[i]  <= home_angle;
                goal_angle[i]     <= home_angle;
                previous_error[i] <= '0;
                previous_time[i]  <= in_word.time_now;
              end
              out_word  <= '{3'd0, home_angle, home_angle, STAT_HOMED};
            end else if (in_word.command == CMD_SET_TARGET && in_range) begin
              goal_angle[in_word.channel] <= set_clamped;
              out_word  <= '{in_word.channel, current_angle[in_word.channel],
                             set_clamped, STAT_TARGET};
            end else if (in_word.command == CMD_STEP && in_range) begin
              state <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          previous_time[ch] <= now;
          if (eval_mag < $signed({1'b0, dead_zone})) begin
            previous_error[ch] <= '0;
            stat  <= STAT_DEADZONE;
            state <= ST_FIN;
          end else if (eval_dus < MIN_DT_US) begin
            stat  <= STAT_DT_SMALL;
            state <= ST_FIN;
          end else begin
            err   <= eval_err;
            diff  <= eval_diff;
            dus   <= eval_dus;
            state <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          prod  <= product;
          state <= ST_MUL_S;
        end
        ST_MUL_S: begin
          dsign   <= dprod[35];
          numq    <= product[DIV_NUM_W-1:0];
          rem     <= '0;
          den     <= dus;
          div_cnt <= '0;
          state   <= ST_DIV_D;
        end
        ST_DIV_D: begin
          numq    <= {numq[DIV_NUM_W-3:0], q_a, q_b};
          rem     <= rem_b;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_MUL_V;
          end
        end
        ST_MUL_V: begin
          dquo  <= numq[45:0];
          prod  <= product;
          state <= ST_MUL_R;
        end
        ST_MUL_R: begin
          // A speed-time product of 2^37 or more gives a limit well past any
          // reachable angle, so the limit saturates there.
          vlim  <= (prod[55:37] != '0) ? LIM_SAT : product[62:45];
          state <= ST_MUL_P;
        end
        ST_MUL_P: begin
          prod  <= product;
          state <= ST_SUM;
        end
        ST_SUM: begin
          outv  <= sum[47] ? -$signed({2'b0, sum_mag[46:8]}) : $signed({2'b0, sum_mag[46:8]});
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          current_angle[ch]  <= nv_clamped;
          previous_error[ch] <= $signed({1'b0, goal_angle[ch]}) - $signed({1'b0, nv_clamped});
          stat  <= STAT_MOVED;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_word  <= '{ch, current_angle[ch], goal_angle[ch], stat};
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_step_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_word.command == CMD_STEP && in_range) |=> state == ST_EVAL)
    else $error("accepted step did not start evaluation");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN || $past(state) == ST_IDLE))
    else $error("result raised outside idle or finish");

  a_div_handoff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_D && div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> state == ST_MUL_V)
    else $error("derivative division did not hand over to limit product");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_D) |=> !$past(in_accept))
    else $error("word accepted during division");

endmodule
